@@ rtl/assert_macros.svh @@
// Assertion macros shared by the decompressor modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check on every clock edge once reset has been released.
`define LZD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// Check on every clock edge, reset included.
`define LZD_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) \
    else $error(msg);

`endif

@@ rtl/lzd_pkg.sv @@
// Types, codes and constants shared by the LZRW1-A decompressor modules.
package lzd_pkg;

  // History depth in bytes.
  localparam int LZD_HIST_DEPTH = 4096;
  // Copy offset width fixed by the item format.
  localparam int OFS_W = 12;
  // Header length in bytes.
  localparam logic [2:0] HDR_LEN = 3'd4;
  // First header byte that selects raw mode.
  localparam logic [7:0] RAW_MARK = 8'h01;
  // Items governed by one control word.
  localparam logic [4:0] ITEMS_PER_CTRL = 5'd16;
  // Copy length bias.
  localparam logic [4:0] LEN_BIAS = 5'd3;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       last_in;
  } in_beat_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       bad_offset;
    logic       last_of_run;
    logic       end_of_block;
  } out_beat_t;

  typedef enum logic [1:0] {
    PH_CTRL_LO,
    PH_CTRL_HI,
    PH_ITEM,
    PH_OFS_LO
  } phase_e;

  typedef enum logic [1:0] {
    S_ACCEPT,
    S_READ,
    S_WRITE
  } lzd_state_e;

  typedef enum logic [1:0] {
    K_NONE,
    K_EMIT,
    K_COPY
  } lzd_kind_e;

  typedef struct packed {
    logic accept;
    logic read;
    logic write;
  } lzd_cmd_t;

  typedef struct packed {
    lzd_kind_e kind;
    logic      out_free;
    logic      copy_final;
  } lzd_sts_t;

endpackage

@@ rtl/lzd_stream_if.sv @@
// Valid/ready stream channel carrying one payload beat.
interface lzd_stream_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ rtl/lzrw1a_block_decompressor.sv @@
// LZRW1-A block decompressor, one compressed byte accepted per beat. Header,
// control and raw or literal bytes are taken whenever the output is free. A
// copy of L bytes (L = 3..18) holds the input back: each copied byte is a
// registered read of the 4096-byte history followed by its store and output,
// because a short offset may read the byte just written. A stalled output
// beat adds its wait. The history needs no clearing pass: a copy that reaches
// past the bytes produced in this block is flagged with bad_offset instead.
module lzrw1a_block_decompressor import lzd_pkg::*; #(
  parameter int HistDepth = LZD_HIST_DEPTH
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  lzd_stream_if.sink    in_i,
  lzd_stream_if.source  out_o
);

  lzd_cmd_t  cmd;
  lzd_sts_t  sts;
  in_beat_t  in_data;
  out_beat_t out_data;

  assign in_data    = in_i.data;
  assign out_o.data = out_data;

  // Sequencer
  lzd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // Datapath
  lzd_datapath #(
    .HistDepth (HistDepth)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .out_data_o  (out_data)
  );

endmodule

@@ rtl/lzd_ctrl.sv @@
// Sequencer of the decompressor: input acceptance and copy read/write steps.
`include "assert_macros.svh"

module lzd_ctrl import lzd_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  lzd_sts_t sts_i,
  output lzd_cmd_t cmd_o
);

  lzd_state_e state_q, state_d;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_ACCEPT;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and commands
  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    unique case (state_q)
      S_ACCEPT: begin
        in_ready_o = sts_i.out_free;
        if (in_valid_i && sts_i.out_free) begin
          cmd_o.accept = 1'b1;
          if (sts_i.kind == K_COPY) begin
            state_d = S_READ;
          end
        end
      end
      S_READ: begin
        cmd_o.read = 1'b1;
        state_d    = S_WRITE;
      end
      S_WRITE: begin
        if (sts_i.out_free) begin
          cmd_o.write = 1'b1;
          state_d     = sts_i.copy_final ? S_ACCEPT : S_READ;
        end
      end
      default: begin
        state_d = S_ACCEPT;
      end
    endcase
  end

  `LZD_ASSERT(a_read_then_write, state_q == S_READ |=> state_q == S_WRITE, "read not followed by write")
  `LZD_ASSERT(a_write_waits, (state_q == S_WRITE && !sts_i.out_free) |=> state_q == S_WRITE, "copy byte left before output freed")
  `LZD_ASSERT(a_no_accept_in_copy, (state_q != S_ACCEPT) |-> !in_ready_o, "input taken during a copy")

endmodule

@@ rtl/lzd_datapath.sv @@
// Datapath of the decompressor: block state, history memory and output register.
`include "assert_macros.svh"

module lzd_datapath import lzd_pkg::*; #(
  parameter int HistDepth = LZD_HIST_DEPTH
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  in_beat_t  in_data_i,
  input  lzd_cmd_t  cmd_i,
  output lzd_sts_t  sts_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_beat_t out_data_o
);

  localparam int AW = $clog2(HistDepth);

  // History memory
  logic [7:0] hist_mem [HistDepth];

  logic [AW-1:0] wp_q, wp_d;
  logic [AW:0]   prod_q, prod_d;
  logic [2:0]    hdr_q, hdr_d;
  logic          raw_q, raw_d;
  logic [15:0]   ctrl_q, ctrl_d;
  logic [4:0]    items_q, items_d;
  phase_e        phase_q, phase_d;
  logic [7:0]    pend_q, pend_d;
  logic [4:0]    left_q, left_d;
  logic          last_q, last_d;
  logic [AW-1:0] ofs_q, ofs_d;
  logic [7:0]    rd_q;
  logic          out_valid_q;
  out_beat_t     out_q;

  logic [7:0]     in_b;
  logic           in_last;
  logic [OFS_W-1:0] ofs_w;
  logic [4:0]     len_w;
  logic           bad;
  lzd_kind_e      kind;
  logic           emit_data;
  logic           emit_bad;
  logic           lit_store;
  logic           restart;
  logic [4:0]     items_dec;
  logic           mem_we;
  logic [7:0]     mem_wdata;

  assign in_b    = in_data_i.in_byte;
  assign in_last = in_data_i.last_in;
  assign ofs_w   = {pend_q[7:4], in_b};
  assign len_w   = {1'b0, pend_q[3:0]} + LEN_BIAS;
  assign bad     = (ofs_w == '0) || ((AW+1)'(ofs_w) > prod_q);

  // Classify the byte on the input channel
  always_comb begin
    kind      = K_NONE;
    emit_data = 1'b0;
    emit_bad  = 1'b0;
    lit_store = 1'b0;
    if (hdr_q < HDR_LEN) begin
      kind = K_NONE;
    end else if (raw_q) begin
      kind      = K_EMIT;
      emit_data = 1'b1;
    end else begin
      unique case (phase_q)
        PH_CTRL_LO, PH_CTRL_HI: begin
          kind = K_NONE;
        end
        PH_ITEM: begin
          if (!ctrl_q[0]) begin
            kind      = K_EMIT;
            emit_data = 1'b1;
            lit_store = 1'b1;
          end
        end
        PH_OFS_LO: begin
          if (bad) begin
            kind     = K_EMIT;
            emit_bad = 1'b1;
          end else begin
            kind = K_COPY;
          end
        end
        default: begin
          kind = K_NONE;
        end
      endcase
    end
    // End marker when the final byte gives nothing else
    if (in_last && kind == K_NONE) begin
      kind = K_EMIT;
    end
  end

  assign items_dec = (items_q != '0) ? items_q - 5'd1 : items_q;

  // Block state update
  always_comb begin
    wp_d    = wp_q;
    prod_d  = prod_q;
    hdr_d   = hdr_q;
    raw_d   = raw_q;
    ctrl_d  = ctrl_q;
    items_d = items_q;
    phase_d = phase_q;
    pend_d  = pend_q;
    left_d  = left_q;
    last_d  = last_q;
    ofs_d   = ofs_q;
    restart = 1'b0;
    if (cmd_i.accept) begin
      if (hdr_q < HDR_LEN) begin
        if (hdr_q == '0) begin
          raw_d = (in_b == RAW_MARK);
        end
        hdr_d = hdr_q + 3'd1;
      end else if (!raw_q) begin
        unique case (phase_q)
          PH_CTRL_LO: begin
            ctrl_d  = {8'h00, in_b};
            phase_d = PH_CTRL_HI;
          end
          PH_CTRL_HI: begin
            ctrl_d  = {in_b, ctrl_q[7:0]};
            items_d = ITEMS_PER_CTRL;
            phase_d = PH_ITEM;
          end
          PH_ITEM: begin
            if (!ctrl_q[0]) begin
              wp_d    = wp_q + 1'b1;
              prod_d  = (prod_q == (AW+1)'(HistDepth)) ? prod_q : prod_q + 1'b1;
              ctrl_d  = ctrl_q >> 1;
              items_d = items_dec;
              phase_d = (items_dec == '0) ? PH_CTRL_LO : PH_ITEM;
            end else begin
              pend_d  = in_b;
              phase_d = PH_OFS_LO;
            end
          end
          PH_OFS_LO: begin
            ctrl_d  = ctrl_q >> 1;
            items_d = items_dec;
            phase_d = (items_dec == '0) ? PH_CTRL_LO : PH_ITEM;
            if (!bad) begin
              ofs_d  = AW'(ofs_w);
              left_d = len_w;
              last_d = in_last;
            end
          end
          default: begin
            phase_d = PH_CTRL_LO;
          end
        endcase
      end
      restart = in_last && (kind != K_COPY);
    end else if (cmd_i.write) begin
      wp_d    = wp_q + 1'b1;
      prod_d  = (prod_q == (AW+1)'(HistDepth)) ? prod_q : prod_q + 1'b1;
      left_d  = left_q - 5'd1;
      restart = (left_q == 5'd1) && last_q;
    end
    // Start the next block fresh
    if (restart) begin
      wp_d    = '0;
      prod_d  = '0;
      hdr_d   = '0;
      raw_d   = 1'b0;
      ctrl_d  = '0;
      items_d = '0;
      phase_d = PH_CTRL_LO;
      pend_d  = '0;
      last_d  = 1'b0;
    end
  end

  // Control state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q    <= '0;
      prod_q  <= '0;
      hdr_q   <= '0;
      raw_q   <= 1'b0;
      ctrl_q  <= '0;
      items_q <= '0;
      phase_q <= PH_CTRL_LO;
      pend_q  <= '0;
      left_q  <= '0;
      last_q  <= 1'b0;
    end else begin
      wp_q    <= wp_d;
      prod_q  <= prod_d;
      hdr_q   <= hdr_d;
      raw_q   <= raw_d;
      ctrl_q  <= ctrl_d;
      items_q <= items_d;
      phase_q <= phase_d;
      pend_q  <= pend_d;
      left_q  <= left_d;
      last_q  <= last_d;
    end
  end

  // Copy offset register
  always_ff @(posedge clk_i) begin
    ofs_q <= ofs_d;
  end

  // Store literals and copied bytes
  assign mem_we    = (cmd_i.accept && lit_store) || cmd_i.write;
  assign mem_wdata = cmd_i.write ? rd_q : in_b;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      hist_mem[wp_q] <= mem_wdata;
    end
  end

  // Fetch the copy source byte
  always_ff @(posedge clk_i) begin
    if (cmd_i.read) begin
      rd_q <= hist_mem[wp_q - ofs_q];
    end
  end

  // Output register: load a beat, drop it once taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if ((cmd_i.accept && kind == K_EMIT) || cmd_i.write) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept && kind == K_EMIT) begin
      out_q.out_byte     <= emit_data ? in_b : 8'h00;
      out_q.byte_valid   <= emit_data;
      out_q.bad_offset   <= emit_bad;
      out_q.last_of_run  <= 1'b1;
      out_q.end_of_block <= in_last;
    end else if (cmd_i.write) begin
      out_q.out_byte     <= rd_q;
      out_q.byte_valid   <= 1'b1;
      out_q.bad_offset   <= 1'b0;
      out_q.last_of_run  <= (left_q == 5'd1);
      out_q.end_of_block <= (left_q == 5'd1) && last_q;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign out_data_o       = out_q;
  assign sts_o.kind       = kind;
  assign sts_o.out_free   = !out_valid_q || out_ready_i;
  assign sts_o.copy_final = (left_q == 5'd1);

  `LZD_ASSERT(a_prod_bound, prod_q <= (AW+1)'(HistDepth), "produced count past history depth")
  `LZD_ASSERT(a_out_held, (out_valid_q && !out_ready_i) |=> out_valid_q, "pending output beat lost")
  `LZD_ASSERT(a_copy_end_restart, (cmd_i.write && left_q == 5'd1 && last_q) |=> (wp_q == '0 && hdr_q == '0), "block not restarted after final copy")

endmodule

@@ sim/lzrw1a_block_decompressor_test.sv @@
// Randomized self-checking testbench for the LZRW1-A block decompressor.
`timescale 1ns / 100ps

module lzrw1a_block_decompressor_test;
  import lzd_pkg::*;

  typedef logic [7:0] byte_q_t[$];

  // Rebuilds the output stream from the compressed bytes and checks result beats.
  class rebuild_board;
    logic [7:0]  hist [LZD_HIST_DEPTH];
    logic [11:0] wr_ptr;
    logic [12:0] produced;
    logic [2:0]  hdr_cnt;
    logic        raw;
    logic [15:0] ctrl;
    logic [4:0]  items_left;
    phase_e      phase;
    logic [7:0]  pending;
    out_beat_t   due_beats[$];
    int          errors;
    int          seen;

    function new();
      errors = 0;
      seen = 0;
      restart();
    endfunction

    // Drop all block state; history contents stay.
    function void restart();
      wr_ptr = '0;
      produced = '0;
      hdr_cnt = '0;
      raw = 1'b0;
      ctrl = '0;
      items_left = '0;
      phase = PH_CTRL_LO;
      pending = '0;
    endfunction

    function out_beat_t make_beat(logic [7:0] b, logic valid, logic bad);
      return '{out_byte: b, byte_valid: valid, bad_offset: bad,
               last_of_run: 1'b0, end_of_block: 1'b0};
    endfunction

    function void put_byte(logic [7:0] b);
      hist[wr_ptr] = b;
      wr_ptr = wr_ptr + 12'd1;
      if (produced < 13'(LZD_HIST_DEPTH)) produced = produced + 13'd1;
    endfunction

    // Use up one control bit.
    function void end_item();
      ctrl = ctrl >> 1;
      if (items_left > 0) items_left = items_left - 5'd1;
      phase = (items_left == 0) ? PH_CTRL_LO : PH_ITEM;
    endfunction

    // Predict the result beats caused by one compressed byte.
    function void take_byte(in_beat_t beat);
      out_beat_t   run[$];
      out_beat_t   tail;
      logic [11:0] ofs;
      logic [4:0]  len;
      logic [7:0]  v;
      logic [7:0]  b;
      b = beat.in_byte;
      if (hdr_cnt < HDR_LEN) begin
        if (hdr_cnt == 0) raw = (b == RAW_MARK);
        hdr_cnt = hdr_cnt + 3'd1;
      end else if (raw) begin
        run.push_back(make_beat(b, 1'b1, 1'b0));
      end else begin
        case (phase)
          PH_CTRL_LO: begin
            ctrl = {8'h00, b};
            phase = PH_CTRL_HI;
          end
          PH_CTRL_HI: begin
            ctrl[15:8] = b;
            items_left = ITEMS_PER_CTRL;
            phase = PH_ITEM;
          end
          PH_ITEM: begin
            if (!ctrl[0]) begin
              put_byte(b);
              run.push_back(make_beat(b, 1'b1, 1'b0));
              end_item();
            end else begin
              pending = b;
              phase = PH_OFS_LO;
            end
          end
          default: begin
            ofs = {pending[7:4], b};
            len = {1'b0, pending[3:0]} + LEN_BIAS;
            // Flag a copy that points at nothing or before the block start.
            if (ofs == 0 || {1'b0, ofs} > produced) begin
              run.push_back(make_beat(8'h00, 1'b0, 1'b1));
            end else begin
              for (int i = 0; i < len; i++) begin
                v = hist[wr_ptr - ofs];
                put_byte(v);
                run.push_back(make_beat(v, 1'b1, 1'b0));
              end
            end
            end_item();
          end
        endcase
      end
      // Final byte with no data gets a bare end marker.
      if (beat.last_in && run.size() == 0) run.push_back(make_beat(8'h00, 1'b0, 1'b0));
      if (run.size() > 0) begin
        tail = run.pop_back();
        tail.last_of_run = 1'b1;
        tail.end_of_block = beat.last_in;
        run.push_back(tail);
      end
      if (beat.last_in) restart();
      foreach (run[i]) due_beats.push_back(run[i]);
    endfunction

    task report(string what);
      $display("mismatch at result %0d: %s", seen, what);
      errors++;
    endtask

    // Compare one result beat with the oldest prediction.
    task match_beat(out_beat_t got);
      out_beat_t want;
      if (due_beats.size() == 0) begin
        report($sformatf("unexpected beat %p", got));
      end else begin
        want = due_beats.pop_front();
        if (got.out_byte !== want.out_byte)
          report($sformatf("out_byte %h, want %h", got.out_byte, want.out_byte));
        if (got.byte_valid !== want.byte_valid)
          report($sformatf("byte_valid %b, want %b", got.byte_valid, want.byte_valid));
        if (got.bad_offset !== want.bad_offset)
          report($sformatf("bad_offset %b, want %b", got.bad_offset, want.bad_offset));
        if (got.last_of_run !== want.last_of_run)
          report($sformatf("last_of_run %b, want %b", got.last_of_run, want.last_of_run));
        if (got.end_of_block !== want.end_of_block)
          report($sformatf("end_of_block %b, want %b", got.end_of_block, want.end_of_block));
      end
      seen++;
    endtask

    task check_drained();
      if (due_beats.size() != 0)
        report($sformatf("%0d predicted beats never arrived", due_beats.size()));
    endtask
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  bit   calm = 1'b0;
  int   beats_sent = 0;
  rebuild_board board;

  lzd_stream_if #(.payload_t(in_beat_t))  in_ch ();
  lzd_stream_if #(.payload_t(out_beat_t)) out_ch ();

  lzrw1a_block_decompressor i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  always #1 clk_i = ~clk_i;

  // Mostly back to back, some short gaps, a few long ones.
  function automatic int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Offer one compressed byte, hold it until taken, then predict its results.
  // Results only follow the accepting edge, so the prediction is in time.
  task automatic push_byte(input logic [7:0] b, input logic fin);
    int       gap;
    in_beat_t beat;
    gap = pick_gap();
    beat = '{in_byte: b, last_in: fin};
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.data <= beat;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    board.take_byte(beat);
    beats_sent++;
  endtask

  task automatic send_block(input byte_q_t q);
    foreach (q[i]) push_byte(q[i], i == q.size() - 1);
  endtask

  // Compressed block with random literals and copies, mostly with legal offsets.
  function automatic byte_q_t packed_block(int n_items);
    byte_q_t     q;
    logic [15:0] cw;
    logic [11:0] ofs;
    logic [3:0]  ln;
    logic [7:0]  first;
    int          made;
    int          slot;
    first = 8'($urandom_range(0, 255));
    if (first == RAW_MARK) first = 8'h00;
    q = {first, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
         8'($urandom_range(0, 255))};
    made = 0;
    for (int k = 0; k < n_items; k++) begin
      slot = k % 16;
      if (slot == 0) begin
        cw = 16'($urandom);
        q.push_back(cw[7:0]);
        q.push_back(cw[15:8]);
      end
      if (!cw[slot]) begin
        q.push_back(8'($urandom_range(0, 255)));
        made++;
      end else begin
        ln = 4'($urandom_range(0, 15));
        // Mostly legal offsets, short ones often so copies overlap their output.
        if (made > 0 && $urandom_range(0, 9) < 8) begin
          if ($urandom_range(0, 1) == 1)
            ofs = 12'($urandom_range(1, (made < 24) ? made : 24));
          else
            ofs = 12'($urandom_range(1, (made < 4095) ? made : 4095));
        end else begin
          ofs = 12'($urandom);
        end
        q.push_back({ofs[11:8], ln});
        q.push_back(ofs[7:0]);
        if (ofs != 0 && ofs <= made) made += ln + 3;
      end
    end
    return q;
  endfunction

  // Stimulus.
  initial begin
    byte_q_t blk;
    int      roll;
    int      n;
    board = new();
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Raw block: both byte extremes pass through.
    send_block({RAW_MARK, 8'h00, 8'h00, 8'h00, 8'h00, 8'hFF});
    // Block cut off inside the header.
    send_block({8'h05});
    // Block cut off between the two control bytes.
    send_block({8'h00, 8'h00, 8'h00, 8'h00, 8'hAB});
    // Literals 00 and FF, zero offset, offset past the output, longest copy
    // at offset 1, shortest copy at offset 2, then a cut inside a copy.
    send_block({8'h00, 8'hFF, 8'hFF, 8'hFF, 8'h7C, 8'h00,
                8'h00, 8'hFF, 8'h0F, 8'h00, 8'hF0, 8'hFF,
                8'h0F, 8'h01, 8'h00, 8'h02, 8'h3F});

    // Random blocks, mostly well formed.
    while (beats_sent < 190) begin
      roll = $urandom_range(0, 99);
      calm = ($urandom_range(0, 4) == 0);
      if (roll < 60) begin
        blk = packed_block($urandom_range(3, 36));
      end else if (roll < 75) begin
        blk = {RAW_MARK, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
               8'($urandom_range(0, 255))};
        n = $urandom_range(1, 30);
        repeat (n) blk.push_back(8'($urandom_range(0, 255)));
      end else if (roll < 90) begin
        // Broken block: trim the tail at a random point.
        blk = packed_block($urandom_range(1, 12));
        n = $urandom_range(1, 3);
        repeat (n) if (blk.size() > 1) void'(blk.pop_back());
      end else begin
        blk = {};
        n = $urandom_range(1, 12);
        repeat (n) blk.push_back(8'($urandom_range(0, 255)));
      end
      send_block(blk);
    end
    calm = 1'b0;
    in_ch.valid <= 1'b0;

    // Drain, then watch for stray beats.
    while (board.due_beats.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    board.check_drained();
    if (board.errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Result side: random backpressure, check every beat taken.
  initial begin
    out_beat_t got;
    int        gap;
    out_ch.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      gap = pick_gap();
      if (gap > 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk_i);
      while (!out_ch.valid) @(posedge clk_i);
      got = out_ch.data;
      board.match_beat(got);
    end
  end

  // Watchdog.
  initial begin
    #2000000;
    $display("status: fail");
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+rtl
rtl/lzd_pkg.sv
rtl/lzd_stream_if.sv
rtl/lzd_ctrl.sv
rtl/lzd_datapath.sv
rtl/lzrw1a_block_decompressor.sv
sim/lzrw1a_block_decompressor_test.sv
